// File: hw/rtl/lrupt_pkg.sv
`default_nettype none

package lrupt_pkg;

	localparam int PAGE_W = 8;
	localparam int TIME_W = 32;
	localparam int CNT_W = 9;
	localparam int KIND_W = 2;
	localparam int STATUS_W = 2;
	localparam int DEF_CAPACITY = 256;

	// Operation codes carried by the kind field.
	localparam logic [KIND_W-1:0] KIND_TOUCH = 2'd0;
	localparam logic [KIND_W-1:0] KIND_REMOVE = 2'd1;
	localparam logic [KIND_W-1:0] KIND_EVICT = 2'd2;

	// Result codes carried by the status field.
	localparam logic [STATUS_W-1:0] ST_DONE = 2'd0;
	localparam logic [STATUS_W-1:0] ST_EVICTED = 2'd1;
	localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;
	localparam logic [STATUS_W-1:0] ST_FULL = 2'd3;

	// Broadcast command to every cell of the chain.
	typedef struct packed {
		logic rot;
		logic drop;
		logic ins;
		logic [CNT_W-1:0] cnt;
		logic [PAGE_W-1:0] page;
		logic [TIME_W-1:0] tm;
	} cell_ctrl_t;

endpackage

`default_nettype wire

// File: hw/rtl/lru_page_replacement_table.sv
`default_nettype none

// LRU page table built as a chain of CAPACITY list cells that hold pages and
// last-use times in list order, with the head cell watched by one compare
// unit. Every operation walks the occupied list by rotating it through the
// head, one entry per cycle, so the list is back in its original order when
// the walk ends. A touch updates the time of a matching entry as it passes
// the head, or appends the page after the walk; a remove or an evict drops
// the chosen entry as it reaches the head, which closes the gap in order.
// A touch, a remove or an unused kind code makes one walk over the whole
// list even when it changes nothing, and an evict on a non-empty list makes
// two walks (one walk finds the oldest time, the second removes it).
// The block takes one transaction at a time; a new request is accepted as
// soon as the previous result sits in the output register, even while that
// result is still waiting to be taken. There are no clearing passes.
module lru_page_replacement_table #(
	parameter int CAPACITY = lrupt_pkg::DEF_CAPACITY
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          req_valid,
	output logic                               req_ready,
	input  wire logic [lrupt_pkg::KIND_W-1:0]   kind,
	input  wire logic [lrupt_pkg::PAGE_W-1:0]   vpn,
	input  wire logic [lrupt_pkg::TIME_W-1:0]   tick,
	output logic                               rsp_valid,
	input  wire logic                          rsp_ready,
	output logic      [lrupt_pkg::STATUS_W-1:0] status,
	output logic      [lrupt_pkg::PAGE_W-1:0]   evicted_page,
	output logic      [lrupt_pkg::CNT_W-1:0]    occupancy
);
	import lrupt_pkg::*;

	localparam int IdxW = $clog2(CAPACITY);
	localparam logic [CNT_W-1:0] Cap = CNT_W'(CAPACITY);

	// One-hot sequencer: walk the list, second walk for evict, hand off result.
	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_SCAN = 4'b0010,
		S_DROP = 4'b0100,
		S_DONE = 4'b1000
	} state_t;

	state_t state_q;
	logic [KIND_W-1:0] kind_q;
	logic [PAGE_W-1:0] vpn_q;
	logic [TIME_W-1:0] tick_q;
	logic [CNT_W-1:0] cnt_q;
	logic [CNT_W-1:0] n_q;
	logic [CNT_W-1:0] step_q;
	logic found_q;
	logic [TIME_W-1:0] best_t_q;
	logic [IdxW-1:0] best_i_q;
	logic [STATUS_W-1:0] res_status_q;
	logic [PAGE_W-1:0] res_page_q;

	logic rsp_valid_q;
	logic [STATUS_W-1:0] status_q;
	logic [PAGE_W-1:0] evicted_page_q;
	logic [CNT_W-1:0] occupancy_q;

	cell_ctrl_t ctrl;
	logic [PAGE_W-1:0] cell_page [CAPACITY];
	logic [TIME_W-1:0] cell_time [CAPACITY];
	logic [PAGE_W-1:0] head_page;
	logic [TIME_W-1:0] head_time;
	logic head_match;
	logic walking;
	logic out_free;

	assign head_page = cell_page[0];
	assign head_time = cell_time[0];
	assign head_match = (head_page == vpn_q);
	assign walking = (step_q != n_q);
	assign out_free = !rsp_valid_q || rsp_ready;
	assign req_ready = (state_q == S_IDLE);

	// Command for the cell chain, decoded from the sequencer state.
	always_comb begin
		ctrl.rot = 1'b0;
		ctrl.drop = 1'b0;
		ctrl.ins = 1'b0;
		ctrl.cnt = cnt_q;
		ctrl.page = head_page;
		ctrl.tm = head_time;
		if (state_q == S_SCAN) begin
			if (walking) begin
				unique case (kind_q)
					KIND_TOUCH: begin
						ctrl.rot = 1'b1;
						if (head_match) begin
							ctrl.tm = tick_q;
						end
					end
					KIND_REMOVE: begin
						ctrl.drop = head_match && !found_q;
						ctrl.rot = !(head_match && !found_q);
					end
					KIND_EVICT: begin
						ctrl.rot = 1'b1;
					end
					default: begin
					end
				endcase
			end else if (kind_q == KIND_TOUCH && !found_q && cnt_q < Cap) begin
				// Append a new page behind the last resident entry.
				ctrl.ins = 1'b1;
				ctrl.page = vpn_q;
				ctrl.tm = tick_q;
			end
		end else if (state_q == S_DROP && walking) begin
			ctrl.drop = (step_q[IdxW-1:0] == best_i_q);
			ctrl.rot = (step_q[IdxW-1:0] != best_i_q);
		end
	end

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic [PAGE_W-1:0] nxt_page;
		logic [TIME_W-1:0] nxt_time;
		if (i == CAPACITY - 1) begin : g_end
			assign nxt_page = '0;
			assign nxt_time = '0;
		end else begin : g_mid
			assign nxt_page = cell_page[i+1];
			assign nxt_time = cell_time[i+1];
		end
		lrupt_cell #(
			.IDX(i)
		) u_cell (
			.clk(clk),
			.ctrl(ctrl),
			.nxt_page(nxt_page),
			.nxt_time(nxt_time),
			.page(cell_page[i]),
			.tm(cell_time[i])
		);
	end

	// Payload registers of the current transaction and the walk bookkeeping.
	always_ff @(posedge clk) begin
		if (req_valid && req_ready) begin
			kind_q <= kind;
			vpn_q <= vpn;
			tick_q <= tick;
			found_q <= 1'b0;
			res_status_q <= ST_DONE;
			res_page_q <= '0;
		end else if (state_q == S_SCAN) begin
			if (walking) begin
				if (head_match) begin
					found_q <= 1'b1;
				end
				if (kind_q == KIND_EVICT && (step_q == '0 || head_time < best_t_q)) begin
					// Strict compare keeps the earliest position on equal times.
					best_t_q <= head_time;
					best_i_q <= step_q[IdxW-1:0];
				end
			end else if (kind_q == KIND_TOUCH && !found_q && cnt_q >= Cap) begin
				res_status_q <= ST_FULL;
			end else if (kind_q == KIND_EVICT && n_q == '0) begin
				res_status_q <= ST_EMPTY;
			end
		end else if (state_q == S_DROP && walking && ctrl.drop) begin
			res_status_q <= ST_EVICTED;
			res_page_q <= head_page;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q <= '0;
			n_q <= '0;
			step_q <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						state_q <= S_SCAN;
						n_q <= cnt_q;
						step_q <= '0;
					end
				end
				S_SCAN: begin
					if (walking) begin
						step_q <= step_q + 1'b1;
						if (ctrl.drop) begin
							cnt_q <= cnt_q - 1'b1;
						end
					end else begin
						if (ctrl.ins) begin
							cnt_q <= cnt_q + 1'b1;
						end
						if (kind_q == KIND_EVICT && n_q != '0) begin
							step_q <= '0;
							state_q <= S_DROP;
						end else begin
							state_q <= S_DONE;
						end
					end
				end
				S_DROP: begin
					if (walking) begin
						step_q <= step_q + 1'b1;
						if (ctrl.drop) begin
							cnt_q <= cnt_q - 1'b1;
						end
					end else begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Output register: holds one result until the consumer takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (state_q == S_DONE && out_free) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_DONE && out_free) begin
			status_q <= res_status_q;
			evicted_page_q <= res_page_q;
			occupancy_q <= cnt_q;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign status = status_q;
	assign evicted_page = evicted_page_q;
	assign occupancy = occupancy_q;

endmodule

`default_nettype wire

// File: hw/rtl/lrupt_cell.sv
`default_nettype none

// One list slot. In a rotate each occupied slot below the last takes its upper
// neighbor and the last takes the broadcast word; in a drop the wrap is left out.
module lrupt_cell #(
	parameter int IDX = 0
) (
	input  wire logic                        clk,
	input  wire lrupt_pkg::cell_ctrl_t       ctrl,
	input  wire logic [lrupt_pkg::PAGE_W-1:0] nxt_page,
	input  wire logic [lrupt_pkg::TIME_W-1:0] nxt_time,
	output logic      [lrupt_pkg::PAGE_W-1:0] page,
	output logic      [lrupt_pkg::TIME_W-1:0] tm
);
	import lrupt_pkg::*;

	localparam logic [CNT_W-1:0] Idx = CNT_W'(IDX);
	localparam logic [CNT_W-1:0] IdxNext = CNT_W'(IDX + 1);

	logic [PAGE_W-1:0] page_q;
	logic [TIME_W-1:0] time_q;
	logic take_nxt;
	logic take_bcast;

	always_comb begin
		take_nxt = (ctrl.rot || ctrl.drop) && (IdxNext < ctrl.cnt);
		take_bcast = (ctrl.rot && (IdxNext == ctrl.cnt)) || (ctrl.ins && (Idx == ctrl.cnt));
	end

	always_ff @(posedge clk) begin
		if (take_nxt) begin
			page_q <= nxt_page;
			time_q <= nxt_time;
		end else if (take_bcast) begin
			page_q <= ctrl.page;
			time_q <= ctrl.tm;
		end
	end

	assign page = page_q;
	assign tm = time_q;

endmodule

`default_nettype wire

// File: hw/rtl/lrupt_checker.sv
`default_nettype none

module lrupt_checker #(
	parameter int CAPACITY = lrupt_pkg::DEF_CAPACITY
) (
	input wire logic                          clk,
	input wire logic                          arst_n,
	input wire logic                          rsp_valid,
	input wire logic                          rsp_ready,
	input wire logic [lrupt_pkg::STATUS_W-1:0] status,
	input wire logic [lrupt_pkg::PAGE_W-1:0]   evicted_page,
	input wire logic [lrupt_pkg::CNT_W-1:0]    occupancy
);
	import lrupt_pkg::*;

	localparam logic [CNT_W-1:0] Cap = CNT_W'(CAPACITY);

	// A result never reports more entries than the list can hold.
	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> occupancy <= Cap)
		else $error("occupancy above capacity");

	// An empty-list evict leaves nothing resident.
	a_empty_occ: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && status == ST_EMPTY |-> occupancy == '0)
		else $error("empty status with entries resident");

	// A dropped insert only happens on a full list.
	a_full_occ: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && status == ST_FULL |-> occupancy == Cap)
		else $error("full status on a list that is not full");

	// The page field is zero unless a page was evicted.
	a_page_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && status != ST_EVICTED |-> evicted_page == '0)
		else $error("evicted page set without an eviction");

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(status) && $stable(occupancy))
		else $error("result changed while stalled");

endmodule

bind lru_page_replacement_table lrupt_checker #(
	.CAPACITY(CAPACITY)
) u_lrupt_checker (.*);

`default_nettype wire

// File: dv/lru_page_replacement_table_tb.sv
`default_nettype none

// Self-checking testbench for the LRU page replacement table.
//
// The test tasks below drive transactions through one shared sender task. At
// the moment a request transaction is accepted, the sender runs it through
// the testbench's own model of the table and queues the expected response. A
// separate checker process pops that queue for every accepted response
// transaction and compares status, evicted page and occupancy field by field.
// The receiver drops rsp_ready on a pattern of its own. The sender works in
// bursts with random gaps between them, so gaps and stalls land at every
// point of the block's list walks.
module lru_page_replacement_table_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import lrupt_pkg::*;

	localparam int TABLE_DEPTH = DEF_CAPACITY;
	// The kind field has one code that the block treats as a no-op.
	localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
	localparam int HOLD_OFF_CYCLES = 300;

	typedef struct packed {
		logic [PAGE_W-1:0] page;
		logic [TIME_W-1:0] tm;
	} resident_page_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [PAGE_W-1:0] page;
		logic [CNT_W-1:0] occ;
	} table_result_t;

	typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_RHYTHM} rx_mode_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_ready;
	logic [KIND_W-1:0] kind = KIND_TOUCH;
	logic [PAGE_W-1:0] vpn = '0;
	logic [TIME_W-1:0] tick = '0;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	logic [STATUS_W-1:0] status;
	logic [PAGE_W-1:0] evicted_page;
	logic [CNT_W-1:0] occupancy;

	// Model of the list contents, in list order, and the responses still owed.
	resident_page_t resident[$];
	table_result_t pending_results[$];

	int errors = 0;
	int sent_count = 0;
	int status_count[4] = '{0, 0, 0, 0};
	int peak_occupancy = 0;

	// Sender burst control.
	int burst_left = 0;
	bit sender_steady = 1'b0;

	// Receiver stall control.
	bit hold_request = 1'b0;
	int hold_left = 0;
	int rx_left = 0;
	rx_mode_t rx_mode = RX_OPEN;

	lru_page_replacement_table #(
		.CAPACITY(TABLE_DEPTH)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.kind(kind),
		.vpn(vpn),
		.tick(tick),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.status(status),
		.evicted_page(evicted_page),
		.occupancy(occupancy)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	// Applies one request to the model of the list and returns the response the
	// block owes for it. A touch refreshes a matching page or appends a new one;
	// a remove deletes a match and keeps the order of the rest; an evict takes
	// the smallest time, with the earliest position winning a tie.
	function automatic table_result_t lru_table_apply(input logic [KIND_W-1:0] k,
			input logic [PAGE_W-1:0] p, input logic [TIME_W-1:0] t);
		table_result_t r;
		resident_page_t fresh;
		int hit;
		int oldest;
		r = '0;
		r.status = ST_DONE;
		hit = -1;
		foreach (resident[i]) begin
			if (hit < 0 && resident[i].page == p) begin
				hit = i;
			end
		end
		case (k)
			KIND_TOUCH: begin
				if (hit >= 0) begin
					resident[hit].tm = t;
				end else if (resident.size() < TABLE_DEPTH) begin
					fresh.page = p;
					fresh.tm = t;
					resident.push_back(fresh);
				end else begin
					r.status = ST_FULL;
				end
			end
			KIND_REMOVE: begin
				if (hit >= 0) begin
					resident.delete(hit);
				end
			end
			KIND_EVICT: begin
				if (resident.size() == 0) begin
					r.status = ST_EMPTY;
				end else begin
					oldest = 0;
					foreach (resident[i]) begin
						if (resident[i].tm < resident[oldest].tm) begin
							oldest = i;
						end
					end
					r.status = ST_EVICTED;
					r.page = resident[oldest].page;
					resident.delete(oldest);
				end
			end
			default: begin
			end
		endcase
		r.occ = CNT_W'(resident.size());
		status_count[r.status]++;
		if (resident.size() > peak_occupancy) begin
			peak_occupancy = resident.size();
		end
		return r;
	endfunction

	// Sends one request transaction. At the start of each burst the sender may
	// drop valid for a random gap; within a burst valid stays high, so the
	// next request follows right on the acceptance edge of the previous one.
	task automatic send_op(input logic [KIND_W-1:0] k, input logic [PAGE_W-1:0] p,
			input logic [TIME_W-1:0] t);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 16);
			gap = sender_steady ? 0 : $urandom_range(0, 7);
			if (gap > 0) begin
				req_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		req_valid <= 1'b1;
		kind <= k;
		vpn <= p;
		tick <= t;
		@(posedge clk);
		while (!req_ready) @(posedge clk);
		pending_results.push_back(lru_table_apply(k, p, t));
		sent_count++;
	endtask

	// Empty-list behavior: evict reports empty, and a remove of an absent page
	// and the unused kind code both complete with nothing changed.
	task automatic test_empty_table();
		send_op(KIND_EVICT, 8'hff, '1);
		send_op(KIND_REMOVE, 8'h00, '0);
		send_op(KIND_UNUSED, 8'h3c, 32'h1234_5678);
	endtask

	// Extremes of page and time, a refresh of a resident page, ties on the
	// oldest time, a remove from the middle of the list, and an evict of the
	// whole list down to empty.
	task automatic test_edge_values();
		send_op(KIND_TOUCH, 8'h00, 32'h0000_0000);
		send_op(KIND_TOUCH, 8'hff, 32'hffff_ffff);
		send_op(KIND_TOUCH, 8'h55, 32'haaaa_aaaa);
		send_op(KIND_TOUCH, 8'haa, 32'h5555_5555);
		// Refreshing page 0 moves it from the oldest time to the newest.
		send_op(KIND_TOUCH, 8'h00, 32'hffff_ffff);
		// Page 7 ties with page 0xaa, which sits earlier and so goes first.
		send_op(KIND_TOUCH, 8'h07, 32'h5555_5555);
		send_op(KIND_REMOVE, 8'h55, '1);
		send_op(KIND_REMOVE, 8'h13, '0);
		send_op(KIND_UNUSED, 8'hff, '1);
		send_op(KIND_EVICT, 8'h00, '0);
		send_op(KIND_EVICT, 8'hff, '1);
		// Pages 0 and 0xff tie at the top time; page 0 is earlier.
		send_op(KIND_EVICT, 8'h00, '0);
		send_op(KIND_EVICT, 8'h00, '0);
		send_op(KIND_EVICT, 8'h00, '0);
	endtask

	// Fills every slot of the table with all page numbers in random order,
	// works on the full list, then evicts everything. With the table as deep
	// as the page space, every touch of a full list finds its page.
	task automatic test_fill_to_capacity();
		logic [PAGE_W-1:0] order [TABLE_DEPTH];
		logic [PAGE_W-1:0] swap;
		logic [TIME_W-1:0] t;
		int j;
		for (int i = 0; i < TABLE_DEPTH; i++) begin
			order[i] = PAGE_W'(i);
		end
		for (int i = TABLE_DEPTH - 1; i > 0; i--) begin
			j = $urandom_range(0, i);
			swap = order[i];
			order[i] = order[j];
			order[j] = swap;
		end
		sender_steady = 1'b1;
		t = $urandom;
		for (int i = 0; i < TABLE_DEPTH; i++) begin
			// Repeat the previous time now and then to build ties.
			if ($urandom_range(0, 7) != 0) begin
				t = $urandom;
			end
			if (i == 10) begin
				t = '0;
			end else if (i == 20) begin
				t = '1;
			end
			send_op(KIND_TOUCH, order[i], t);
		end
		sender_steady = 1'b0;
		for (int i = 0; i < 32; i++) begin
			send_op(KIND_TOUCH, PAGE_W'($urandom), $urandom);
		end
		send_op(KIND_UNUSED, PAGE_W'($urandom), $urandom);
		// Open one slot and fill it again while the list is near full.
		j = $urandom_range(0, TABLE_DEPTH - 1);
		send_op(KIND_REMOVE, order[j], $urandom);
		send_op(KIND_TOUCH, order[j], '0);
		for (int i = 0; i <= TABLE_DEPTH; i++) begin
			send_op(KIND_EVICT, PAGE_W'($urandom), $urandom);
		end
	endtask

	// The receiver refuses responses for a long stretch while the sender keeps
	// offering requests back to back, so one response waits in the output
	// register and the block then has to stall its request side.
	task automatic test_receiver_hold_off();
		sender_steady = 1'b1;
		hold_request = 1'b1;
		for (int i = 0; i < 10; i++) begin
			if (i % 3 == 2) begin
				send_op(KIND_EVICT, PAGE_W'($urandom), $urandom);
			end else begin
				send_op(KIND_TOUCH, PAGE_W'($urandom_range(0, 7)), $urandom);
			end
		end
		sender_steady = 1'b0;
	endtask

	// Random traffic in batches. Each batch draws pages from a window of its
	// own, mostly narrow so pages hit often and the list stays short, and
	// sometimes the whole page space. Times mostly creep forward with repeats,
	// which gives ties for the evict search, with random and extreme values
	// mixed in. Evicts are favored once the list grows, to keep walks short.
	task automatic test_random_workload(input int n_items);
		int pool;
		int roll;
		logic [PAGE_W-1:0] base;
		logic [PAGE_W-1:0] p;
		logic [TIME_W-1:0] now;
		logic [TIME_W-1:0] t;
		logic [KIND_W-1:0] k;
		now = $urandom;
		pool = 4;
		base = '0;
		for (int i = 0; i < n_items; i++) begin
			if (i % 100 == 0) begin
				roll = $urandom_range(0, 19);
				pool = (roll == 0) ? 256 : (roll < 6) ? 64 : (roll < 12) ? 16 : 4;
				base = PAGE_W'($urandom);
				sender_steady = ($urandom_range(0, 3) == 0);
			end
			now += $urandom_range(0, 3);
			roll = $urandom_range(0, 99);
			if (roll < 4) begin
				t = $urandom_range(0, 1) ? '1 : '0;
			end else if (roll < 14) begin
				t = $urandom;
			end else begin
				t = now;
			end
			p = PAGE_W'(base + $urandom_range(0, pool - 1));
			roll = $urandom_range(0, 99);
			if (resident.size() > 40) begin
				roll = (roll < 40) ? roll : (roll < 55) ? 60 : (roll < 97) ? 80 : 99;
			end
			if (roll < 50) begin
				k = KIND_TOUCH;
			end else if (roll < 68) begin
				k = KIND_REMOVE;
				if (resident.size() > 0 && $urandom_range(0, 9) < 7) begin
					p = resident[$urandom_range(0, resident.size() - 1)].page;
				end
			end else if (roll < 96) begin
				k = KIND_EVICT;
			end else begin
				k = KIND_UNUSED;
			end
			send_op(k, p, t);
		end
		sender_steady = 1'b0;
	endtask

	// Receiver stall pattern. A requested hold-off takes priority; otherwise
	// the receiver moves between always-ready, coin-flip, sparse and rhythmic
	// stretches of random length.
	always @(posedge clk) begin
		if (hold_request) begin
			hold_request = 1'b0;
			hold_left = HOLD_OFF_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			rsp_ready <= 1'b0;
		end else begin
			if (rx_left == 0) begin
				rx_left = $urandom_range(16, 160);
				rx_mode = rx_mode_t'($urandom_range(0, 3));
			end
			rx_left--;
			case (rx_mode)
				RX_OPEN: rsp_ready <= 1'b1;
				RX_COIN: rsp_ready <= ($urandom_range(0, 1) == 1);
				RX_SPARSE: rsp_ready <= ($urandom_range(0, 3) == 0);
				default: rsp_ready <= (rx_left % 3 != 0);
			endcase
		end
	end

	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			errors++;
			$display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
		end
	endtask

	// Every accepted response transaction is matched against the oldest
	// expectation. A response with nothing owed is an error on its own.
	always @(posedge clk) begin
		table_result_t want;
		if (arst_n && rsp_valid && rsp_ready) begin
			if (pending_results.size() == 0) begin
				errors++;
				$display({"%0t: unexpected response, expected none ",
					"actual status %0d page %0d occupancy %0d"},
					$time, status, evicted_page, occupancy);
			end else begin
				want = pending_results.pop_front();
				check_field("status", 32'(want.status), 32'(status));
				check_field("evicted_page", 32'(want.page), 32'(evicted_page));
				check_field("occupancy", 32'(want.occ), 32'(occupancy));
			end
		end
	end

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_empty_table();
		test_edge_values();
		test_fill_to_capacity();
		test_receiver_hold_off();
		test_random_workload(1000);
		req_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		// Long enough for a full evict walk, so any stray response shows up.
		repeat (2 * TABLE_DEPTH + 8) @(posedge clk);
		$display("Covered %0d requests: %0d evictions, %0d evicts on an empty list,",
			sent_count, status_count[ST_EVICTED], status_count[ST_EMPTY]);
		$display("%0d plain completions, peak list length %0d of %0d.",
			status_count[ST_DONE], peak_occupancy, TABLE_DEPTH);
		if (errors == 0) begin
			$display("lru_page_replacement_table_tb passed");
		end else begin
			$display("lru_page_replacement_table_tb failed");
		end
		$finish;
	end

	// Watchdog: several times the slowest legal run.
	initial begin
		#100ms;
		$display("lru_page_replacement_table_tb failed");
		$finish;
	end

endmodule

`default_nettype wire
